// File: sv/saf_pkg.sv
// ----------------------------------------------------------------------------
// saf_pkg: shared types and constants of the spring force accumulator
// Function codes, sequencer states, square root / divide unit control and the
// saturating accumulator add.
// ----------------------------------------------------------------------------
`default_nettype none

package saf_pkg;

  // input function codes
  localparam logic [1:0] FUNC_WRITE_POS = 2'd0;
  localparam logic [1:0] FUNC_APPLY_EDGE = 2'd1;
  localparam logic [1:0] FUNC_READ_FORCE = 2'd2;

  localparam logic [31:0] STIFFNESS_RESET = 32'd65536;

  localparam int ACC_W = 48;
  localparam int FRC_W = 52;   // signed per-axis force, magnitude below 2^51
  localparam int QUO_W = 51;   // quotient bits produced by the divider

  localparam logic signed [ACC_W+4:0] ACC_MAX = 53'sd140737488355327;
  localparam logic signed [ACC_W+4:0] ACC_MIN = -53'sd140737488355328;

  typedef enum logic {
    SQD_SQRT,
    SQD_DIV
  } sqd_op_t;

  typedef struct packed {
    logic    start;
    sqd_op_t op;
  } sqd_ctl_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDF,
    ST_PI,
    ST_PJ,
    ST_SQM,
    ST_SQA,
    ST_SQS,
    ST_SQW,
    ST_LEN,
    ST_KM,
    ST_KLO,
    ST_KHI,
    ST_KSUM,
    ST_DVS,
    ST_DVW,
    ST_FRI,
    ST_FUI,
    ST_FUJ,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_K,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef struct packed {
    logic                  clip;
    logic signed [ACC_W-1:0] val;
  } sat_t;

  // accumulator plus force, clamped to the 48-bit signed range
  function automatic sat_t sat_add(input logic signed [ACC_W-1:0] acc,
                                   input logic signed [FRC_W-1:0] f);
    logic signed [ACC_W+4:0] sum;
    sat_t r;
    sum = ACC_W'(0) + {{5{acc[ACC_W-1]}}, acc} + {f[FRC_W-1], f};
    r.clip = 1'b0;
    if (sum > ACC_MAX) begin
      r.clip = 1'b1;
      r.val = ACC_MAX[ACC_W-1:0];
    end else if (sum < ACC_MIN) begin
      r.clip = 1'b1;
      r.val = ACC_MIN[ACC_W-1:0];
    end else begin
      r.val = sum[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/saf_if.sv
// ----------------------------------------------------------------------------
// saf_if: valid/ready channels of the spring force accumulator
// Command channel in, result channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface saf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [9:0]         first_vertex;
  logic [9:0]         second_vertex;
  logic [31:0]        rest_length;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, func, first_vertex, second_vertex, rest_length,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, func, first_vertex, second_vertex, rest_length,
                pos_x, pos_y, pos_z, output ready);
endinterface

interface saf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic               edge_skipped;
  logic               saturated;

  modport source (output valid, force_x, force_y, force_z, edge_skipped, saturated,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, edge_skipped, saturated,
                output ready);
endinterface

`default_nettype wire

// File: sv/saf_mul.sv
// ----------------------------------------------------------------------------
// saf_mul: shared registered multiplier
// Unsigned 33 x 33 product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_mul (
  input  wire logic        clk,
  input  wire logic [32:0] a,
  input  wire logic [32:0] b,
  output logic      [65:0] p_r
);

  // register the product
  always_ff @(posedge clk) begin
    p_r <= 66'(a) * 66'(b);
  end

endmodule

`default_nettype wire

// File: sv/saf_sqdiv.sv
// ----------------------------------------------------------------------------
// saf_sqdiv: shared square root and divide unit
// Restoring bit-serial unit: two radicand bits per step for the square root
// (33 steps), one numerator bit per step for the division (51 steps).
// ----------------------------------------------------------------------------
`default_nettype none

module saf_sqdiv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire saf_pkg::sqd_ctl_t ctl,
  input  wire logic [65:0]       radicand,
  input  wire logic [97:0]       numer,
  input  wire logic [48:0]       divisor,
  output logic                   done_r,
  output logic [50:0]            res_r
);

  logic              busy_r;
  saf_pkg::sqd_op_t  op_r;
  logic [5:0]        cnt_r;
  logic [97:0]       src_r;
  logic [49:0]       rem_r;
  logic [48:0]       dvs_r;
  logic [51:0]       trial_a;
  logic [51:0]       trial_b;
  logic              ge;
  logic [51:0]       diff;

  // one restoring step: compare, subtract, shift in the result bit
  always_comb begin
    if (op_r == saf_pkg::SQD_SQRT) begin
      trial_a = {rem_r, src_r[97:96]};
      trial_b = {res_r[49:0], 2'b01};
    end else begin
      trial_a = {1'b0, rem_r, src_r[97]};
      trial_b = {3'b000, dvs_r};
    end
    ge   = trial_a >= trial_b;
    diff = trial_a - trial_b;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r  <= ctl.op;
      res_r <= '0;
      dvs_r <= divisor;
      if (ctl.op == saf_pkg::SQD_SQRT) begin
        cnt_r <= 6'd33;
        src_r <= {radicand, 32'd0};
        rem_r <= '0;
      end else begin
        cnt_r <= 6'd51;
        src_r <= {numer[50:0], 47'd0};
        rem_r <= {3'b000, numer[97:51]};
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      res_r <= {res_r[49:0], ge};
      rem_r <= ge ? diff[49:0] : trial_a[49:0];
      if (op_r == saf_pkg::SQD_SQRT) begin
        src_r <= {src_r[95:0], 2'b00};
      end else begin
        src_r <= {src_r[96:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/spring_force_accumulator.sv
// ----------------------------------------------------------------------------
// spring_force_accumulator: mass-spring Hooke force accumulation
// Position and force stores with an iterative spring force datapath.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch (valid/ready); each transaction yields exactly one
// transaction on out_ch. func 0 writes a vertex position, func 1 applies one
// spring edge, func 2 reads a vertex force and clears it. cfg_we/cfg_wdata
// load the spring stiffness (Q16.16); the user writes it only while the block
// is idle, the block itself does not enforce this. The sequencer works around
// one shared multiplier and one bit-serial square root / divide unit; an edge
// runs 33 root steps and three 51-step divisions, and no new command is taken
// until the current one has passed the response state. After reset the force
// store is cleared by a sweep over every vertex; in_ch.ready stays low
// meanwhile, configuration writes are taken.
// A finished result sits in the output register; a new command is accepted
// while it waits, but the next result holds until out_ch takes the first.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_force_accumulator #(
  parameter int VERTEX_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  saf_in_if.sink           in_ch,
  saf_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int XW = AW + 10;

  saf_pkg::state_t  state_r, state_nxt;
  saf_pkg::mul_sel_t mul_sel;
  saf_pkg::sqd_ctl_t sqd_ctl;

  logic [31:0]     k_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [AW-1:0]   i_r, j_r;
  logic [31:0]     rest_r;
  logic [1:0]      ax_r;
  logic            accept;
  logic            vi_ok, vj_ok;
  logic [XW-1:0]   vi_ext, vj_ext;
  logic [AW-1:0]   in_i_addr;

  // stores
  logic [95:0]     pos_mem [VERTEX_COUNT];
  logic [143:0]    frc_mem [VERTEX_COUNT];
  logic [95:0]     pos_rdata_r;
  logic [143:0]    frc_rdata_r;
  logic            pos_we, frc_we;
  logic [AW-1:0]   pos_raddr, frc_raddr, frc_waddr;
  logic [143:0]    frc_wdata;

  // edge datapath
  logic [95:0]     pi_r;
  logic [32:0]     dm_r [3];
  logic            dneg_r [3];
  logic [65:0]     s_r;
  logic [32:0]     len_r;
  logic [32:0]     emag_r;
  logic            eneg_r;
  logic [31:0]     pk_r;
  logic [64:0]     lo_r;
  logic [97:0]     n_r;
  logic signed [saf_pkg::FRC_W-1:0] f_r [3];
  logic [32:0]     mul_a, mul_b;
  logic [65:0]     mul_p;
  logic            sqd_done;
  logic [50:0]     sqd_res;
  logic signed [33:0] e_val;
  logic signed [saf_pkg::FRC_W-1:0] q_signed;
  saf_pkg::sat_t   upd [3];

  // response and output registers
  logic [47:0]     rsp_f_r [3];
  logic            rsp_skip_r, rsp_sat_r;
  logic            out_valid_r;
  logic [47:0]     out_f_r [3];
  logic            out_skip_r, out_sat_r;

  assign accept    = in_ch.valid && in_ch.ready;
  assign vi_ext    = XW'(in_ch.first_vertex);
  assign vj_ext    = XW'(in_ch.second_vertex);
  assign vi_ok     = 32'(vi_ext) < VERTEX_COUNT;
  assign vj_ok     = 32'(vj_ext) < VERTEX_COUNT;
  assign in_i_addr = vi_ext[AW-1:0];
  assign in_ch.ready = (state_r == saf_pkg::ST_IDLE);

  // stiffness register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= saf_pkg::STIFFNESS_RESET;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      saf_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(VERTEX_COUNT - 1)) state_nxt = saf_pkg::ST_IDLE;
      end
      saf_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == saf_pkg::FUNC_READ_FORCE && vi_ok) begin
            state_nxt = saf_pkg::ST_RDF;
          end else if (in_ch.func == saf_pkg::FUNC_APPLY_EDGE && vi_ok && vj_ok) begin
            state_nxt = saf_pkg::ST_PI;
          end else begin
            state_nxt = saf_pkg::ST_RESP;
          end
        end
      end
      saf_pkg::ST_RDF:  state_nxt = saf_pkg::ST_RESP;
      saf_pkg::ST_PI:   state_nxt = saf_pkg::ST_PJ;
      saf_pkg::ST_PJ:   state_nxt = saf_pkg::ST_SQM;
      saf_pkg::ST_SQM:  state_nxt = saf_pkg::ST_SQA;
      saf_pkg::ST_SQA:  state_nxt = (ax_r == 2'd2) ? saf_pkg::ST_SQS : saf_pkg::ST_SQM;
      saf_pkg::ST_SQS:  state_nxt = saf_pkg::ST_SQW;
      saf_pkg::ST_SQW:  if (sqd_done) state_nxt = saf_pkg::ST_LEN;
      saf_pkg::ST_LEN:  state_nxt = (len_r == '0) ? saf_pkg::ST_RESP : saf_pkg::ST_KM;
      saf_pkg::ST_KM:   state_nxt = saf_pkg::ST_KLO;
      saf_pkg::ST_KLO:  state_nxt = saf_pkg::ST_KHI;
      saf_pkg::ST_KHI:  state_nxt = saf_pkg::ST_KSUM;
      saf_pkg::ST_KSUM: state_nxt = saf_pkg::ST_DVS;
      saf_pkg::ST_DVS:  state_nxt = saf_pkg::ST_DVW;
      saf_pkg::ST_DVW: begin
        if (sqd_done) state_nxt = (ax_r == 2'd2) ? saf_pkg::ST_FRI : saf_pkg::ST_KM;
      end
      saf_pkg::ST_FRI:  state_nxt = saf_pkg::ST_FUI;
      saf_pkg::ST_FUI:  state_nxt = saf_pkg::ST_FUJ;
      saf_pkg::ST_FUJ:  state_nxt = saf_pkg::ST_RESP;
      saf_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) state_nxt = saf_pkg::ST_IDLE;
      end
      default: state_nxt = saf_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pos_we    = accept && in_ch.func == saf_pkg::FUNC_WRITE_POS && vi_ok;
    pos_raddr = (state_r == saf_pkg::ST_IDLE) ? in_i_addr : j_r;
    frc_raddr = (state_r == saf_pkg::ST_IDLE) ? in_i_addr :
                (state_r == saf_pkg::ST_FUI) ? j_r : i_r;
    frc_we    = 1'b0;
    frc_waddr = i_r;
    frc_wdata = '0;
    mul_sel   = saf_pkg::MUL_SQ;
    sqd_ctl.start = 1'b0;
    sqd_ctl.op    = saf_pkg::SQD_DIV;
    case (state_r)
      saf_pkg::ST_CLEAR: begin
        frc_we    = 1'b1;
        frc_waddr = clr_cnt_r;
      end
      saf_pkg::ST_RDF: frc_we = 1'b1;
      saf_pkg::ST_FUI: begin
        frc_we    = 1'b1;
        frc_wdata = {upd[2].val, upd[1].val, upd[0].val};
      end
      saf_pkg::ST_FUJ: begin
        frc_we    = 1'b1;
        frc_waddr = j_r;
        frc_wdata = {upd[2].val, upd[1].val, upd[0].val};
      end
      saf_pkg::ST_KM:  mul_sel = saf_pkg::MUL_K;
      saf_pkg::ST_KLO: mul_sel = saf_pkg::MUL_LO;
      saf_pkg::ST_KHI: mul_sel = saf_pkg::MUL_HI;
      saf_pkg::ST_SQS: begin
        sqd_ctl.start = 1'b1;
        sqd_ctl.op    = saf_pkg::SQD_SQRT;
      end
      saf_pkg::ST_DVS: sqd_ctl.start = 1'b1;
      default: begin
      end
    endcase
  end

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= saf_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == saf_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // position store
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[in_i_addr] <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  // force store
  always_ff @(posedge clk) begin
    if (frc_we) frc_mem[frc_waddr] <= frc_wdata;
    frc_rdata_r <= frc_mem[frc_raddr];
  end

  // shared multiplier operands
  always_comb begin
    case (mul_sel)
      saf_pkg::MUL_K: begin
        mul_a = dm_r[ax_r];
        mul_b = {1'b0, k_r};
      end
      saf_pkg::MUL_LO: begin
        mul_a = {1'b0, mul_p[31:0]};
        mul_b = emag_r;
      end
      saf_pkg::MUL_HI: begin
        mul_a = {1'b0, pk_r};
        mul_b = emag_r;
      end
      default: begin
        mul_a = dm_r[ax_r];
        mul_b = dm_r[ax_r];
      end
    endcase
  end

  saf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  saf_sqdiv u_sqdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sqd_ctl),
    .radicand (s_r),
    .numer    (n_r),
    .divisor  ({len_r, 16'd0}),
    .done_r   (sqd_done),
    .res_r    (sqd_res)
  );

  assign e_val    = $signed({1'b0, len_r}) - $signed({2'b00, rest_r});
  assign q_signed = $signed({1'b0, sqd_res});

  // accumulator update: add the force at i, subtract it at j
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      upd[a] = saf_pkg::sat_add($signed(frc_rdata_r[48*a +: 48]),
                                (state_r == saf_pkg::ST_FUJ) ? -f_r[a] : f_r[a]);
    end
  end

  // edge datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      saf_pkg::ST_IDLE: begin
        i_r    <= in_i_addr;
        j_r    <= vj_ext[AW-1:0];
        rest_r <= in_ch.rest_length;
        ax_r   <= 2'd0;
        s_r    <= '0;
      end
      saf_pkg::ST_PI: pi_r <= pos_rdata_r;
      saf_pkg::ST_PJ: begin
        for (int a = 0; a < 3; a++) begin
          logic signed [32:0] d;
          d = $signed({pos_rdata_r[32*a+31], pos_rdata_r[32*a +: 32]})
            - $signed({pi_r[32*a+31], pi_r[32*a +: 32]});
          dneg_r[a] <= d[32];
          dm_r[a]   <= d[32] ? 33'(-d) : 33'(d);
        end
      end
      saf_pkg::ST_SQA: begin
        s_r  <= s_r + mul_p;
        ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      saf_pkg::ST_SQW: if (sqd_done) len_r <= sqd_res[32:0];
      saf_pkg::ST_LEN: begin
        eneg_r <= e_val[33];
        emag_r <= e_val[33] ? 33'(-e_val) : 33'(e_val);
      end
      saf_pkg::ST_KLO: pk_r <= mul_p[63:32];
      saf_pkg::ST_KHI: lo_r <= mul_p[64:0];
      saf_pkg::ST_KSUM: n_r <= 98'(lo_r) + {mul_p[65:0], 32'd0};
      saf_pkg::ST_DVW: begin
        if (sqd_done) begin
          f_r[ax_r] <= (dneg_r[ax_r] != eneg_r) ? -q_signed : q_signed;
          ax_r      <= ax_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // response registers
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < 3; a++) rsp_f_r[a] <= '0;
      rsp_skip_r <= 1'b0;
      rsp_sat_r  <= 1'b0;
    end else begin
      case (state_r)
        saf_pkg::ST_RDF: begin
          for (int a = 0; a < 3; a++) rsp_f_r[a] <= frc_rdata_r[48*a +: 48];
        end
        saf_pkg::ST_LEN: if (len_r == '0) rsp_skip_r <= 1'b1;
        saf_pkg::ST_FUI, saf_pkg::ST_FUJ: begin
          if (upd[0].clip || upd[1].clip || upd[2].clip) rsp_sat_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register: load on a free slot, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == saf_pkg::ST_RESP && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == saf_pkg::ST_RESP && (!out_valid_r || out_ch.ready)) begin
      for (int a = 0; a < 3; a++) out_f_r[a] <= rsp_f_r[a];
      out_skip_r <= rsp_skip_r;
      out_sat_r  <= rsp_sat_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.force_x      = $signed(out_f_r[0]);
  assign out_ch.force_y      = $signed(out_f_r[1]);
  assign out_ch.force_z      = $signed(out_f_r[2]);
  assign out_ch.edge_skipped = out_skip_r;
  assign out_ch.saturated    = out_sat_r;

endmodule

`default_nettype wire

// File: bench/spring_force_accumulator_tb.sv
// ----------------------------------------------------------------------------
// spring_force_accumulator_tb: self-checking bench of the spring force block
// Drives position writes, spring edges and force reads over valid/ready,
// predicts every result with a bit-exact fixed-point Hooke model and checks
// each result transaction in order, across several stiffness settings and
// sender/receiver idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_force_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_VERTS = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [1:0]         func;
    logic [9:0]         vi;
    logic [9:0]         vj;
    logic [31:0]        rest;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } cmd_t;

  typedef struct {
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
    logic               skipped;
    logic               sat;
  } res_t;

  // Hooke force model with its own copy of positions, forces and stiffness
  class force_scoreboard;
    logic signed [31:0] pos [NUM_VERTS][3];
    logic signed [63:0] frc [NUM_VERTS][3];
    logic [31:0]        stiffness;
    res_t               expected_q [$];
    int                 errors;

    function new();
      foreach (frc[v, a]) begin
        frc[v][a] = '0;
        pos[v][a] = '0;
      end
      stiffness = saf_pkg::STIFFNESS_RESET;
      errors = 0;
    endfunction

    function void note_command(cmd_t c);
      res_t r;
      logic signed [33:0] d [3];
      logic [63:0] dm [3];
      logic [67:0] sq;
      logic [67:0] t;
      logic [32:0] len;
      logic signed [34:0] e;
      logic [63:0] emag;
      logic [63:0] p;
      logic [127:0] n;
      logic [127:0] den;
      logic [127:0] q128;
      logic [63:0] q;
      logic signed [63:0] f;
      logic signed [63:0] sum;
      r = '{default: '0};
      case (c.func)
        saf_pkg::FUNC_WRITE_POS: begin
          pos[c.vi][0] = c.px;
          pos[c.vi][1] = c.py;
          pos[c.vi][2] = c.pz;
        end
        saf_pkg::FUNC_READ_FORCE: begin
          r.fx = frc[c.vi][0][47:0];
          r.fy = frc[c.vi][1][47:0];
          r.fz = frc[c.vi][2][47:0];
          for (int a = 0; a < 3; a++) frc[c.vi][a] = '0;
        end
        saf_pkg::FUNC_APPLY_EDGE: begin
          sq = '0;
          for (int a = 0; a < 3; a++) begin
            d[a] = 34'(pos[c.vj][a]) - 34'(pos[c.vi][a]);
            dm[a] = d[a] < 0 ? 64'(-d[a]) : 64'(d[a]);
            sq = sq + 68'(dm[a]) * 68'(dm[a]);
          end
          // bitwise floor square root
          len = '0;
          for (int b = 32; b >= 0; b--) begin
            t = 68'(len | (33'd1 << b));
            if (t * t <= sq) len = t[32:0];
          end
          if (len == 0) begin
            r.skipped = 1'b1;
          end else begin
            e = $signed({2'b0, len}) - $signed({3'b0, c.rest});
            emag = e < 0 ? 64'(-e) : 64'(e);
            den = 128'(len) << 16;
            for (int a = 0; a < 3; a++) begin
              p = dm[a] * 64'(stiffness);
              n = 128'(p) * 128'(emag);
              q128 = n / den;
              q = q128[63:0];
              if (q > (64'd1 << 52)) q = 64'd1 << 52;
              f = ((d[a] < 0) != (e < 0)) ? -$signed(q) : $signed(q);
              sum = frc[c.vi][a] + f;
              frc[c.vi][a] = clamp(sum, r.sat);
              sum = frc[c.vj][a] - f;
              frc[c.vj][a] = clamp(sum, r.sat);
            end
          end
        end
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function logic signed [63:0] clamp(logic signed [63:0] v, inout logic clip);
      if (v > 64'sd140737488355327) begin
        clip = 1'b1;
        return 64'sd140737488355327;
      end
      if (v < -64'sd140737488355328) begin
        clip = 1'b1;
        return -64'sd140737488355328;
      end
      return v;
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      bit bad;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result fx=%0d fy=%0d fz=%0d", $realtime,
                 got.fx, got.fy, got.fz);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      bad = 1'b0;
      if (got.fx !== exp_r.fx) begin
        $display("%0t: force_x expected %0d actual %0d", $realtime, exp_r.fx, got.fx);
        bad = 1'b1;
      end
      if (got.fy !== exp_r.fy) begin
        $display("%0t: force_y expected %0d actual %0d", $realtime, exp_r.fy, got.fy);
        bad = 1'b1;
      end
      if (got.fz !== exp_r.fz) begin
        $display("%0t: force_z expected %0d actual %0d", $realtime, exp_r.fz, got.fz);
        bad = 1'b1;
      end
      if (got.skipped !== exp_r.skipped) begin
        $display("%0t: edge_skipped expected %0b actual %0b", $realtime,
                 exp_r.skipped, got.skipped);
        bad = 1'b1;
      end
      if (got.sat !== exp_r.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $realtime,
                 exp_r.sat, got.sat);
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  int in_idle_pct;
  int out_stall_pct;
  int quiet_cycles;
  force_scoreboard sb;
  bit written [NUM_VERTS];
  int written_q [$];

  saf_in_if in_ch ();
  saf_out_if out_ch ();

  spring_force_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sample accepted transactions and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        sb.note_command('{in_ch.func, in_ch.first_vertex, in_ch.second_vertex,
                          in_ch.rest_length, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z});
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{out_ch.force_x, out_ch.force_y, out_ch.force_z,
                          out_ch.edge_skipped, out_ch.saturated});
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst_n) out_ch.ready = ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_cmd(cmd_t c);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_ch.func = c.func;
    in_ch.first_vertex = c.vi;
    in_ch.second_vertex = c.vj;
    in_ch.rest_length = c.rest;
    in_ch.pos_x = c.px;
    in_ch.pos_y = c.py;
    in_ch.pos_z = c.pz;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (c.func == saf_pkg::FUNC_WRITE_POS && !written[c.vi]) begin
      written[c.vi] = 1'b1;
      written_q = {written_q, int'(c.vi)};
    end
  endtask

  task automatic write_pos(int v, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_cmd('{saf_pkg::FUNC_WRITE_POS, 10'(v), 10'($urandom), $urandom, x, y, z});
  endtask

  task automatic apply_edge(int i, int j, logic [31:0] rest);
    send_cmd('{saf_pkg::FUNC_APPLY_EDGE, 10'(i), 10'(j), rest, $urandom, $urandom,
               $urandom});
  endtask

  task automatic read_force(int v);
    send_cmd('{saf_pkg::FUNC_READ_FORCE, 10'(v), 10'($urandom), $urandom, $urandom,
               $urandom, $urandom});
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // load stiffness only while the block is idle
  task automatic set_stiffness(logic [31:0] k);
    drain();
    @(negedge clk);
    cfg_wdata = k;
    cfg_we = 1'b1;
    @(posedge clk);
    sb.stiffness = k;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(400 * 65536)) - 200 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_rest();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(30 * 65536);
    endcase
  endfunction

  function automatic int rand_vertex();
    return ($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(NUM_VERTS - 1);
  endfunction

  task automatic random_items(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (written_q.size() < 2 || pick < 25) begin
        write_pos(rand_vertex(), rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 70) begin
        apply_edge(written_q[$urandom_range(written_q.size() - 1)],
                   written_q[$urandom_range(written_q.size() - 1)], rand_rest());
      end else if (pick < 97) begin
        read_force(rand_vertex());
      end else begin
        send_cmd('{FUNC_UNUSED, 10'($urandom), 10'($urandom), $urandom, $urandom,
                   $urandom, $urandom});
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    quiet_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.func = saf_pkg::FUNC_WRITE_POS;
    in_ch.first_vertex = '0;
    in_ch.second_vertex = '0;
    in_ch.rest_length = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, zero length, saturation, unused func
    write_pos(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    write_pos(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_pos(2, 32'd0, 32'd0, 32'd0);
    write_pos(3, 32'h0001_0000, 32'd0, 32'hFFFF_0000);
    write_pos(4, 32'd0, 32'd0, 32'd0);
    write_pos(1023, 32'h0001_0000, 32'h0001_0000, 32'd0);
    apply_edge(2, 3, 32'd0);
    apply_edge(2, 3, 32'hFFFF_FFFF);
    apply_edge(2, 4, 32'h0001_0000);
    apply_edge(3, 3, 32'd0);
    apply_edge(1023, 2, 32'h0000_8000);
    apply_edge(0, 1, 32'd0);
    read_force(2);
    read_force(3);
    read_force(1023);
    read_force(500);
    send_cmd('{FUNC_UNUSED, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF});
    set_stiffness(32'hFFFF_FFFF);
    apply_edge(0, 1, 32'd0);
    apply_edge(0, 1, 32'd0);
    apply_edge(2, 3, 32'd0);
    read_force(0);
    read_force(1);
    set_stiffness(32'd0);
    apply_edge(2, 3, 32'd0);
    read_force(2);
    set_stiffness(32'd1);
    apply_edge(1023, 3, 32'hFFFF_FFFF);
    read_force(3);

    // random phases with different idle patterns and stiffness settings
    set_stiffness(saf_pkg::STIFFNESS_RESET);
    random_items(260);
    set_stiffness($urandom_range(8 * 65536, 1));
    in_idle_pct = 50;
    random_items(260);
    set_stiffness($urandom);
    in_idle_pct = 0;
    out_stall_pct = 50;
    random_items(260);
    set_stiffness(32'hFFFF_FFFF);
    in_idle_pct = 14;
    out_stall_pct = 14;
    random_items(260);

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/saf_pkg.sv
sv/saf_if.sv
sv/saf_mul.sv
sv/saf_sqdiv.sv
sv/spring_force_accumulator.sv
bench/spring_force_accumulator_tb.sv
